// ===== sv/nmea_rmc_gga_field_parser_macros.svh =====
// Assertion macros shared by the NMEA RMC/GGA parser checkers.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef NMEA_RMC_GGA_FIELD_PARSER_MACROS_SVH
`define NMEA_RMC_GGA_FIELD_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NRGP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define NRGP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/nrgp_pkg.sv =====
// Shared types, character codes and scale constants for the NMEA parser.
// No dependencies; the parser modules and the testbench import this package.
`timescale 1ns / 1ps

package nrgp_pkg;

	// Fraction digits kept in every converted field (range 0 to 6)
	localparam int FRAC_DIGITS = 4;
	localparam int FRAC_W      = 3;
	localparam int POW_W       = 20;
	localparam int TYPE_LEN    = 5;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_W      = 8'h57;

	// Sentence type strings "GPRMC" and "GPGGA"
	localparam logic [7:0] TYPE_RMC [TYPE_LEN] = '{8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};
	localparam logic [7:0] TYPE_GGA [TYPE_LEN] = '{8'h47, 8'h50, 8'h47, 8'h47, 8'h41};

	// Classified byte as it travels from the front end to the back end
	typedef struct packed {
		logic                dollar;
		logic                star;
		logic                comma;
		logic                digit_ok;
		logic                point;
		logic                minus;
		logic                plus;
		logic                is_a;
		logic                is_s;
		logic                is_w;
		logic [3:0]          digit;
		logic [TYPE_LEN-1:0] rmc_hit;
		logic [TYPE_LEN-1:0] gga_hit;
	} item_t;

	// Scale that pads a field with n fraction digits out to FRAC_DIGITS
	function automatic logic [POW_W-1:0] pad_scale(input logic [FRAC_W-1:0] n);
		logic [POW_W-1:0] p;
		p = POW_W'(1);
		for (int i = 0; i < FRAC_DIGITS; i++) begin
			if (FRAC_W'(i) >= n)
				p = POW_W'(p * POW_W'(10));
		end
		return p;
	endfunction

endpackage

// ===== sv/nrgp_ifs.sv =====
// Stream interfaces of the NMEA parser: received bytes in, fix records out.
// No dependencies.
`timescale 1ns / 1ps

interface nrgp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface nrgp_fix_if;
	logic               valid;
	logic               ready;
	logic               sentence_kind;
	logic               fix_valid;
	logic signed [31:0] utc_time;
	logic signed [31:0] latitude;
	logic signed [31:0] longitude;
	logic signed [31:0] altitude;
	logic signed [31:0] speed;
	logic signed [31:0] course;
	modport source (output valid, output sentence_kind, output fix_valid, output utc_time,
		output latitude, output longitude, output altitude, output speed, output course,
		input ready);
	modport sink (input valid, input sentence_kind, input fix_valid, input utc_time,
		input latitude, input longitude, input altitude, input speed, input course,
		output ready);
endinterface

// ===== sv/nmea_rmc_gga_field_parser.sv =====
// NMEA RMC/GGA sentence parser: takes one received byte per transfer, and gives
// one result per finished or aborted sentence. Depends on nrgp_pkg, the
// interfaces in nrgp_ifs.sv, nrgp_front, nrgp_queue and nrgp_back.
//
// The parser takes one byte every clock cycle while its queue has room. A byte
// passes the classifying front end into a two-entry queue and is acted on by
// the back end in the cycle it reaches the queue head; the '*' or the rejecting
// status letter loads a result into the output register. Only the single
// output register stalls the back end: a byte that would produce a second
// result waits at the queue head until the first one is transferred out, and
// input ready drops once the queue holds two bytes. Each field is converted
// with one multiply-by-ten accumulate per digit; the closing comma or '*'
// scales the field by the missing powers of ten in one multiplier.
`timescale 1ns / 1ps

module nmea_rmc_gga_field_parser import nrgp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	nrgp_byte_if.sink  rx,
	nrgp_fix_if.source fix
);

	logic  q_full;
	logic  push;
	item_t push_item;
	logic  pop;
	logic  head_valid;
	item_t head_item;

	nrgp_front u_front (
		.rx        (rx),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	nrgp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	nrgp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.fix        (fix)
	);

endmodule

// ===== sv/nrgp_front.sv =====
// Front end: accepts received bytes and classifies each one for the back end.
// Depends on nrgp_pkg and nrgp_byte_if.
`timescale 1ns / 1ps

module nrgp_front import nrgp_pkg::*; (
	nrgp_byte_if.sink rx,
	input  logic      q_full,
	output logic      push,
	output item_t     push_item
);

	logic [7:0] ch;

	assign ch       = rx.rx_byte;
	assign rx.ready = !q_full;
	assign push     = rx.valid && !q_full;

	// Decode the character into the flags the back end acts on
	always_comb begin
		push_item          = '0;
		push_item.dollar   = (ch == CH_DOLLAR);
		push_item.star     = (ch == CH_STAR);
		push_item.comma    = (ch == CH_COMMA);
		push_item.digit_ok = (ch >= CH_ZERO) && (ch <= CH_NINE);
		push_item.point    = (ch == CH_POINT);
		push_item.minus    = (ch == CH_MINUS);
		push_item.plus     = (ch == CH_PLUS);
		push_item.is_a     = (ch == CH_A);
		push_item.is_s     = (ch == CH_S);
		push_item.is_w     = (ch == CH_W);
		push_item.digit    = 4'(ch - CH_ZERO);
		for (int k = 0; k < TYPE_LEN; k++) begin
			push_item.rmc_hit[k] = (ch == TYPE_RMC[k]);
			push_item.gga_hit[k] = (ch == TYPE_GGA[k]);
		end
	end

endmodule

// ===== sv/nrgp_queue.sv =====
// Two-entry queue of classified bytes between the front and back ends.
// Depends on nrgp_pkg.
`timescale 1ns / 1ps

module nrgp_queue import nrgp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item  = slot_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== sv/nrgp_back.sv =====
// Back end: sentence state machine, decimal field conversion, stored values
// and the output register. Depends on nrgp_pkg and nrgp_fix_if.
`timescale 1ns / 1ps

module nrgp_back import nrgp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  item_t      head_item,
	output logic       pop,
	nrgp_fix_if.source fix
);

	localparam logic [1:0] PH_WAIT = 2'd0;
	localparam logic [1:0] PH_TYPE = 2'd1;
	localparam logic [1:0] PH_RMC  = 2'd2;
	localparam logic [1:0] PH_GGA  = 2'd3;

	localparam logic [3:0] ROLE_TIME   = 4'd0;
	localparam logic [3:0] ROLE_LAT    = 4'd1;
	localparam logic [3:0] ROLE_LON    = 4'd2;
	localparam logic [3:0] ROLE_ALT    = 4'd3;
	localparam logic [3:0] ROLE_SPEED  = 4'd4;
	localparam logic [3:0] ROLE_COURSE = 4'd5;
	localparam logic [3:0] ROLE_VALUES = 4'd6;
	localparam logic [3:0] ROLE_NONE   = 4'd8;
	localparam logic [3:0] ROLE_STATUS = 4'd9;
	localparam logic [3:0] ROLE_SOUTH  = 4'd10;
	localparam logic [3:0] ROLE_WEST   = 4'd11;

	localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
	localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;
	localparam int          PROD_W    = 32 + POW_W;

	// Parser state
	logic [1:0]        phase_q, phase_d;
	logic [2:0]        tcount_q, tcount_d;
	logic [1:0]        tmatch_q, tmatch_d;
	logic [3:0]        field_q, field_d;
	logic [31:0]       acc_q, acc_d;
	logic [FRAC_W-1:0] frac_q, frac_d;
	logic              nonempty_q, nonempty_d;
	logic              neg_q, neg_d;
	logic              point_q, point_d;
	logic              stop_q, stop_d;
	logic              prev_q, prev_d;
	logic [31:0]       stored_q [6];
	logic [31:0]       stored_d [6];

	// Output register
	logic        out_valid_q;
	logic        kind_q;
	logic        fixok_q;
	logic [31:0] val_q [6];

	logic              emit;
	logic              emit_ok;
	logic              fire;
	logic [3:0]        role;
	logic [2:0]        tk;
	logic [35:0]       mac;
	logic [31:0]       acc_step;
	logic [PROD_W-1:0] prod;
	logic [31:0]       mag;
	logic [31:0]       fin_val;
	logic              store_ok;

	// Map field number to the value it feeds, or to a letter role
	always_comb begin
		role = ROLE_NONE;
		if (phase_q == PH_RMC) begin
			unique case (field_q)
				4'd1:    role = ROLE_TIME;
				4'd2:    role = ROLE_STATUS;
				4'd3:    role = ROLE_LAT;
				4'd4:    role = ROLE_SOUTH;
				4'd5:    role = ROLE_LON;
				4'd6:    role = ROLE_WEST;
				4'd7:    role = ROLE_SPEED;
				4'd8:    role = ROLE_COURSE;
				default: role = ROLE_NONE;
			endcase
		end else begin
			unique case (field_q)
				4'd1:    role = ROLE_TIME;
				4'd2:    role = ROLE_LAT;
				4'd3:    role = ROLE_SOUTH;
				4'd4:    role = ROLE_LON;
				4'd5:    role = ROLE_WEST;
				4'd9:    role = ROLE_ALT;
				default: role = ROLE_NONE;
			endcase
		end
	end

	// Multiply-by-ten accumulate with saturation at 2^31
	assign mac      = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {32'b0, head_item.digit};
	assign acc_step = (mac > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : mac[31:0];

	// Pad missing fraction digits, then apply sign and cap
	assign prod     = {{POW_W{1'b0}}, acc_q} * {32'b0, pad_scale(frac_q)};
	assign mag      = (prod > PROD_W'(MAG_LIMIT)) ? MAG_LIMIT : prod[31:0];
	assign fin_val  = neg_q ? (32'd0 - mag) : ((mag > POS_MAX) ? POS_MAX : mag);
	assign store_ok = (role < ROLE_VALUES) && nonempty_q;

	assign tk = (tcount_q < 3'(TYPE_LEN)) ? tcount_q : 3'(TYPE_LEN - 1);

	// Next-state logic for one classified byte
	always_comb begin
		phase_d    = phase_q;
		tcount_d   = tcount_q;
		tmatch_d   = tmatch_q;
		field_d    = field_q;
		acc_d      = acc_q;
		frac_d     = frac_q;
		nonempty_d = nonempty_q;
		neg_d      = neg_q;
		point_d    = point_q;
		stop_d     = stop_q;
		prev_d     = prev_q;
		stored_d   = stored_q;
		emit       = 1'b0;
		emit_ok    = 1'b0;

		if (head_item.dollar) begin
			phase_d  = PH_TYPE;
			tcount_d = 3'd0;
			tmatch_d = 2'b11;
		end else if (phase_q == PH_TYPE) begin
			if (!head_item.rmc_hit[tk])
				tmatch_d[0] = 1'b0;
			if (!head_item.gga_hit[tk])
				tmatch_d[1] = 1'b0;
			tcount_d = tk + 3'd1;
			if (tk == 3'(TYPE_LEN - 1)) begin
				if (tmatch_d[0])
					phase_d = PH_RMC;
				else if (tmatch_d[1])
					phase_d = PH_GGA;
				else
					phase_d = PH_WAIT;
				field_d    = 4'd0;
				acc_d      = 32'd0;
				frac_d     = '0;
				nonempty_d = 1'b0;
				neg_d      = 1'b0;
				point_d    = 1'b0;
				stop_d     = 1'b0;
				prev_d     = 1'b0;
			end
		end else if (phase_q == PH_RMC || phase_q == PH_GGA) begin
			if (head_item.star || head_item.comma) begin
				// Close the current field
				if (store_ok)
					stored_d[role[2:0]] = fin_val;
				acc_d      = 32'd0;
				frac_d     = '0;
				nonempty_d = 1'b0;
				neg_d      = 1'b0;
				point_d    = 1'b0;
				stop_d     = 1'b0;
				prev_d     = store_ok;
				if (head_item.star) begin
					emit    = 1'b1;
					emit_ok = 1'b1;
					phase_d = PH_WAIT;
				end else if (field_q != 4'd15) begin
					field_d = field_q + 4'd1;
				end
			end else if (role < ROLE_VALUES) begin
				// Feed a numeric field
				if (!nonempty_q && (head_item.minus || head_item.plus)) begin
					nonempty_d = 1'b1;
					neg_d      = head_item.minus;
				end else begin
					nonempty_d = 1'b1;
					if (!stop_q) begin
						if (head_item.digit_ok) begin
							if (!point_q) begin
								acc_d = acc_step;
							end else if (frac_q < FRAC_W'(FRAC_DIGITS)) begin
								acc_d  = acc_step;
								frac_d = frac_q + FRAC_W'(1);
							end
						end else if (head_item.point && !point_q) begin
							point_d = 1'b1;
						end else begin
							stop_d = 1'b1;
						end
					end
				end
			end else begin
				// Letter fields act on their first character only
				nonempty_d = 1'b1;
				if (!nonempty_q) begin
					if (role == ROLE_STATUS && !head_item.is_a) begin
						emit    = 1'b1;
						phase_d = PH_WAIT;
					end
					if (role == ROLE_SOUTH && head_item.is_s && prev_q)
						stored_d[1] = (stored_q[1] == MAG_LIMIT) ? POS_MAX : 32'd0 - stored_q[1];
					if (role == ROLE_WEST && head_item.is_w && prev_q)
						stored_d[2] = (stored_q[2] == MAG_LIMIT) ? POS_MAX : 32'd0 - stored_q[2];
				end
			end
		end
	end

	// Hold a result-producing byte only while the output register is occupied and not ready
	assign fire = head_valid && (!emit || !out_valid_q || fix.ready);
	assign pop  = fire;

	// Update parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT;
			tcount_q   <= 3'd0;
			tmatch_q   <= 2'b11;
			field_q    <= 4'd0;
			acc_q      <= 32'd0;
			frac_q     <= '0;
			nonempty_q <= 1'b0;
			neg_q      <= 1'b0;
			point_q    <= 1'b0;
			stop_q     <= 1'b0;
			prev_q     <= 1'b0;
			for (int i = 0; i < 6; i++)
				stored_q[i] <= 32'd0;
		end else if (fire) begin
			phase_q    <= phase_d;
			tcount_q   <= tcount_d;
			tmatch_q   <= tmatch_d;
			field_q    <= field_d;
			acc_q      <= acc_d;
			frac_q     <= frac_d;
			nonempty_q <= nonempty_d;
			neg_q      <= neg_d;
			point_q    <= point_d;
			stop_q     <= stop_d;
			prev_q     <= prev_d;
			stored_q   <= stored_d;
		end
	end

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire && emit)
			out_valid_q <= 1'b1;
		else if (fix.ready)
			out_valid_q <= 1'b0;
	end

	// Capture the result payload
	always_ff @(posedge clk) begin
		if (fire && emit) begin
			kind_q  <= (phase_q == PH_GGA);
			fixok_q <= emit_ok;
			val_q   <= stored_d;
		end
	end

	assign fix.valid         = out_valid_q;
	assign fix.sentence_kind = kind_q;
	assign fix.fix_valid     = fixok_q;
	assign fix.utc_time      = val_q[0];
	assign fix.latitude      = val_q[1];
	assign fix.longitude     = val_q[2];
	assign fix.altitude      = val_q[3];
	assign fix.speed         = val_q[4];
	assign fix.course        = val_q[5];

endmodule

// ===== sv/nrgp_checker.sv =====
// Port-level checker for the NMEA parser, bound to the top level.
// Depends on nmea_rmc_gga_field_parser_macros.svh.
`timescale 1ns / 1ps
`include "nmea_rmc_gga_field_parser_macros.svh"

module nrgp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_valid,
	input logic        rx_ready,
	input logic        fix_vld,
	input logic        fix_rdy,
	input logic        sentence_kind,
	input logic        fix_valid,
	input logic [31:0] utc_time,
	input logic [31:0] latitude
);

	// A result stays offered until it is transferred
	`NRGP_ASSERT_NEXT(a_out_hold, fix_vld && !fix_rdy, fix_vld, "result dropped while stalled")

	// A stalled result keeps its kind, fix flag, time and latitude
	`NRGP_ASSERT_NEXT(a_out_stable, fix_vld && !fix_rdy, $stable(sentence_kind) && $stable(fix_valid) && $stable(utc_time) && $stable(latitude), "stalled result changed")

	// Input ready falls only after an input transfer fills the queue
	`NRGP_ASSERT_NOW(a_ready_fall, $fell(rx_ready), $past(rx_valid && rx_ready), "ready fell without a transfer")

	// Only RMC sentences can abort on their status
	`NRGP_ASSERT_NOW(a_abort_rmc, fix_vld && !fix_valid, !sentence_kind, "aborted result is not RMC")

endmodule

bind nmea_rmc_gga_field_parser nrgp_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rx_valid      (rx.valid),
	.rx_ready      (rx.ready),
	.fix_vld       (fix.valid),
	.fix_rdy       (fix.ready),
	.sentence_kind (fix.sentence_kind),
	.fix_valid     (fix.fix_valid),
	.utc_time      (fix.utc_time),
	.latitude      (fix.latitude)
);

// ===== sim/nmea_rmc_gga_field_parser_tb.sv =====
// Testbench of nmea_rmc_gga_field_parser: feeds NMEA byte streams and checks every fix record
// against a cycle-free model of the parser. Depends on nrgp_pkg, nrgp_ifs.sv and the parser.
`timescale 1ns / 1ps

module nmea_rmc_gga_field_parser_tb import nrgp_pkg::*; ();

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 16;

	// Letters that the package does not name
	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_V = 8'h56;

	// Field roles: 0 to 5 index the stored values, the rest are skipped or letter fields
	localparam int SLOT_TIME   = 0;
	localparam int SLOT_LAT    = 1;
	localparam int SLOT_LON    = 2;
	localparam int SLOT_ALT    = 3;
	localparam int SLOT_SPEED  = 4;
	localparam int SLOT_COURSE = 5;
	localparam int FLD_SKIP    = 8;
	localparam int FLD_STATUS  = 9;
	localparam int FLD_NS      = 10;
	localparam int FLD_EW      = 11;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_TYPE, SCAN_RMC, SCAN_GGA} scan_phase_e;

	typedef struct {
		logic        kind;
		logic        ok;
		logic [31:0] vals [6];
	} fix_rec_t;

	logic clk = 1'b0;
	logic arst_n;

	nrgp_byte_if rx_if ();
	nrgp_fix_if  fix_if ();

	nmea_rmc_gga_field_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if),
		.fix(fix_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Parser model state
	scan_phase_e scan_phase;
	logic [2:0]  type_cnt;
	logic [1:0]  type_hits;
	logic [3:0]  field_idx;
	logic [31:0] num_acc;
	logic [2:0]  frac_cnt;
	logic        f_nonempty, f_neg, f_point, f_stop, f_stored;
	logic [31:0] fix_store [6];

	fix_rec_t    fix_expect [$];
	logic [7:0]  tx_bytes [$];
	int          byte_total;
	int          bytes_taken = 0;
	int          fail_count = 0;
	int          cycle_count = 0;
	int          src_wait, sink_wait, sink_draw;
	logic        src_calm, sink_calm;
	string       slot_names [6] = '{"utc_time", "latitude", "longitude", "altitude", "speed",
		"course"};

	// ---------------------------------------------------------------- model

	function automatic logic [31:0] times_ten_plus(input logic [31:0] acc, input logic [3:0] d);
		logic [63:0] t;
		t = 64'(acc) * 64'd10 + 64'(d);
		if (t > 64'h8000_0000)
			t = 64'h8000_0000;
		return t[31:0];
	endfunction

	function automatic logic [31:0] negate_sat(input logic [31:0] v);
		return (v == 32'h8000_0000) ? 32'h7FFF_FFFF : 32'd0 - v;
	endfunction

	function automatic int role_of(input logic gga, input int idx);
		if (!gga) begin
			case (idx)
				1: return SLOT_TIME;
				2: return FLD_STATUS;
				3: return SLOT_LAT;
				4: return FLD_NS;
				5: return SLOT_LON;
				6: return FLD_EW;
				7: return SLOT_SPEED;
				8: return SLOT_COURSE;
				default: return FLD_SKIP;
			endcase
		end
		case (idx)
			1: return SLOT_TIME;
			2: return SLOT_LAT;
			3: return FLD_NS;
			4: return SLOT_LON;
			5: return FLD_EW;
			9: return SLOT_ALT;
			default: return FLD_SKIP;
		endcase
	endfunction

	task automatic clear_field(input logic keep);
		num_acc = '0;
		frac_cnt = '0;
		f_nonempty = 1'b0;
		f_neg = 1'b0;
		f_point = 1'b0;
		f_stop = 1'b0;
		f_stored = keep;
	endtask

	task automatic reset_model();
		scan_phase = SCAN_IDLE;
		type_cnt = '0;
		type_hits = 2'b11;
		field_idx = '0;
		clear_field(1'b0);
		for (int i = 0; i < 6; i++)
			fix_store[i] = '0;
	endtask

	// Pad the field to full scale and store it if it carries a value
	task automatic close_field();
		int role;
		logic [31:0] mag;
		role = role_of(scan_phase == SCAN_GGA, field_idx);
		if (role <= SLOT_COURSE && f_nonempty) begin
			mag = num_acc;
			for (int n = frac_cnt; n < FRAC_DIGITS; n++)
				mag = times_ten_plus(mag, 4'd0);
			if (f_neg)
				fix_store[role] = 32'd0 - mag;
			else
				fix_store[role] = (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
			clear_field(1'b1);
		end else begin
			clear_field(1'b0);
		end
	endtask

	task automatic feed_digit(input logic [7:0] c);
		if (!f_nonempty) begin
			f_nonempty = 1'b1;
			if (c == CH_MINUS) begin
				f_neg = 1'b1;
				return;
			end
			if (c == CH_PLUS)
				return;
		end
		if (f_stop)
			return;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			if (!f_point) begin
				num_acc = times_ten_plus(num_acc, 4'(c - CH_ZERO));
			end else if (frac_cnt < FRAC_DIGITS) begin
				num_acc = times_ten_plus(num_acc, 4'(c - CH_ZERO));
				frac_cnt = frac_cnt + 3'd1;
			end
		end else if (c == CH_POINT && !f_point) begin
			f_point = 1'b1;
		end else begin
			f_stop = 1'b1;
		end
	endtask

	task automatic emit_fix(input logic ok);
		fix_rec_t rec;
		rec.kind = (scan_phase == SCAN_GGA);
		rec.ok = ok;
		for (int i = 0; i < 6; i++)
			rec.vals[i] = fix_store[i];
		fix_expect.push_back(rec);
		scan_phase = SCAN_IDLE;
	endtask

	// Advance the model by one received byte
	task automatic parse_byte(input logic [7:0] c);
		int role;
		logic lead;
		logic [2:0] k;
		if (c == CH_DOLLAR) begin
			scan_phase = SCAN_TYPE;
			type_cnt = '0;
			type_hits = 2'b11;
			return;
		end
		if (scan_phase == SCAN_TYPE) begin
			k = (type_cnt < TYPE_LEN) ? type_cnt : 3'(TYPE_LEN - 1);
			if (c != TYPE_RMC[k])
				type_hits[0] = 1'b0;
			if (c != TYPE_GGA[k])
				type_hits[1] = 1'b0;
			type_cnt = k + 3'd1;
			if (type_cnt >= TYPE_LEN) begin
				if (type_hits[0])
					scan_phase = SCAN_RMC;
				else if (type_hits[1])
					scan_phase = SCAN_GGA;
				else
					scan_phase = SCAN_IDLE;
				field_idx = '0;
				clear_field(1'b0);
			end
			return;
		end
		if (scan_phase != SCAN_RMC && scan_phase != SCAN_GGA)
			return;
		if (c == CH_STAR) begin
			close_field();
			emit_fix(1'b1);
			return;
		end
		if (c == CH_COMMA) begin
			close_field();
			if (field_idx != 4'd15)
				field_idx = field_idx + 4'd1;
			return;
		end
		role = role_of(scan_phase == SCAN_GGA, field_idx);
		if (role <= SLOT_COURSE) begin
			feed_digit(c);
			return;
		end
		lead = !f_nonempty;
		f_nonempty = 1'b1;
		if (!lead)
			return;
		if (role == FLD_STATUS && c != CH_A)
			emit_fix(1'b0);
		else if (role == FLD_NS && c == CH_S && f_stored)
			fix_store[SLOT_LAT] = negate_sat(fix_store[SLOT_LAT]);
		else if (role == FLD_EW && c == CH_W && f_stored)
			fix_store[SLOT_LON] = negate_sat(fix_store[SLOT_LON]);
	endtask

	// ---------------------------------------------------------------- stimulus

	task automatic put_byte(input logic [7:0] b);
		tx_bytes.push_back(b);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic put_digit();
		put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
	endtask

	// Printable byte that cannot end a field or a sentence
	function automatic logic [7:0] filler();
		logic [7:0] b;
		do
			b = 8'($urandom_range(33, 126));
		while (b == CH_DOLLAR || b == CH_COMMA || b == CH_STAR);
		return b;
	endfunction

	task automatic put_number();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return;
		if (pick == 1) begin
			// long enough to saturate
			if ($urandom_range(0, 1))
				put_byte(CH_MINUS);
			repeat ($urandom_range(10, 14))
				put_byte(8'(CH_ZERO + $urandom_range(5, 9)));
			return;
		end
		if ($urandom_range(0, 9) == 0)
			put_byte(CH_MINUS);
		else if ($urandom_range(0, 19) == 0)
			put_byte(CH_PLUS);
		repeat ($urandom_range(0, 6))
			put_digit();
		if ($urandom_range(0, 3) != 0) begin
			put_byte(CH_POINT);
			repeat ($urandom_range(0, 7))
				put_digit();
		end
		if ($urandom_range(0, 14) == 0) begin
			put_byte(($urandom_range(0, 1)) ? CH_POINT : filler());
			repeat ($urandom_range(0, 3))
				put_digit();
		end
	endtask

	task automatic put_hemi(input logic [7:0] pos, input logic [7:0] neg);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			put_byte(pos);
		else if (pick < 8)
			put_byte(neg);
		else if (pick == 9)
			repeat ($urandom_range(1, 2))
				put_byte(filler());
	endtask

	task automatic put_status();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 16)
			put_byte(CH_A);
		else if (pick < 18)
			put_byte(CH_V);
		else if (pick == 18)
			put_byte(filler());
		if (pick < 16 && $urandom_range(0, 9) == 0)
			put_byte(filler());
	endtask

	task automatic put_sentence(input logic gga);
		int nf;
		int role;
		put_str(gga ? "$GPGGA" : "$GPRMC");
		nf = gga ? 14 : 12;
		if ($urandom_range(0, 9) == 0)
			nf = $urandom_range(0, 20);
		for (int f = 1; f <= nf; f++) begin
			put_byte(CH_COMMA);
			role = role_of(gga, f);
			case (role)
				FLD_STATUS: put_status();
				FLD_NS: put_hemi(CH_N, CH_S);
				FLD_EW: put_hemi(CH_E, CH_W);
				FLD_SKIP: begin
					repeat ($urandom_range(0, 3))
						put_byte(filler());
				end
				default: put_number();
			endcase
			// rare line noise inside a field
			if ($urandom_range(0, 199) == 0)
				put_byte(8'($urandom_range(0, 255)));
		end
		put_byte(CH_STAR);
		put_str($sformatf("%02X\r\n", $urandom_range(0, 255)));
	endtask

	task automatic put_broken();
		int pick;
		pick = $urandom_range(0, 5);
		case (pick)
			0: begin
				// cut off, the next dollar restarts
				put_str(($urandom_range(0, 1)) ? "$GPGGA" : "$GPRMC");
				repeat ($urandom_range(1, 5)) begin
					put_byte(CH_COMMA);
					put_number();
				end
			end
			1: begin
				put_str("$GP");
				repeat (3)
					put_byte(filler());
				put_str(",1,2*00\r\n");
			end
			2: put_str(($urandom_range(0, 1)) ? "$GPGGA*00\r\n" : "$GPRMC*00\r\n");
			3: put_str("$GPR");
			4: begin
				repeat ($urandom_range(1, 8))
					put_byte(8'($urandom_range(0, 255)));
			end
			default: put_str("$GNRMC,1,A*00\r\n");
		endcase
	endtask

	task automatic build_stimulus();
		string directed [16];
		int pick;
		directed = '{
			"$GPRMC,123519.123,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\r\n",
			"$GPGGA,123519,4807.038,S,01131.000,W,1,08,0.9,545.4,M,46.9,M,,*47\r\n",
			"$GPRMC,1,V,2,S*00\r\n",
			"$GPGGA,,,,,,,,,,*00\r\n",
			"$GPGGA,99999999999,,,,,,,,-99999999999*00\r\n",
			"$GPRMC,,A,-999999999,S,,W*00\r\n",
			"$GPRMC,1.23456789,A,.5,N,+7.,E,1.2.3,12a34*00\r\n",
			"$GPRMC*00\r\n",
			"$GPGGA,111,$GPRMC,222,A*00\r\n",
			"$GPGSV,1,2,3*00\r\n$XXRMC,1*00\r\n",
			"$GPGGA,,,,,,,,,,,,,,,,,,,,5*00\r\n",
			"$GPGGA,abc,-,S,+,W*00\r\n",
			"$GPRMC,5,,6,NS,7,EW,8,9*00\r\n",
			"$GPRMC,,AV,,S,-.5,W,,*00\r\n",
			"$GPRMC,1,x*00\r\n",
			"$GPGGA,-0.00001,2147483.6479,N,2147483.6478,E*00\r\n"
		};
		// extreme byte values while idle
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'h80);
		put_byte(8'h7F);
		foreach (directed[i])
			put_str(directed[i]);
		// mostly well-formed sentences, some broken ones and noise
		while (tx_bytes.size() < 1400) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				put_sentence($urandom_range(0, 1));
			end else if (pick < 90) begin
				put_broken();
			end else begin
				repeat ($urandom_range(1, 6))
					put_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what);
		if (fail_count < 50)
			$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		fail_count++;
	endtask

	task automatic check_fix();
		fix_rec_t want;
		fix_rec_t got;
		got.kind = fix_if.sentence_kind;
		got.ok = fix_if.fix_valid;
		got.vals = '{fix_if.utc_time, fix_if.latitude, fix_if.longitude, fix_if.altitude,
			fix_if.speed, fix_if.course};
		if (fix_expect.size() == 0) begin
			report_mismatch("fix record with no sentence pending");
			return;
		end
		want = fix_expect.pop_front();
		if (got.kind !== want.kind)
			report_mismatch($sformatf("sentence_kind got %b want %b", got.kind, want.kind));
		if (got.ok !== want.ok)
			report_mismatch($sformatf("fix_valid got %b want %b", got.ok, want.ok));
		for (int i = 0; i < 6; i++)
			if (got.vals[i] !== want.vals[i])
				report_mismatch($sformatf("%s got %0d want %0d", slot_names[i],
					$signed(got.vals[i]), $signed(want.vals[i])));
	endtask

	function automatic int draw_idle(input logic calm);
		return calm ? 0 : $urandom_range(0, 10);
	endfunction

	// ---------------------------------------------------------------- driver

	// Hold each byte until its transfer, then idle for the drawn gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_if.valid <= 1'b0;
			rx_if.rx_byte <= 8'h00;
			src_wait <= 0;
			src_calm <= 1'b0;
		end else if (!rx_if.valid || rx_if.ready) begin
			if (src_wait != 0) begin
				rx_if.valid <= 1'b0;
				src_wait <= src_wait - 1;
			end else if (tx_bytes.size() != 0) begin
				rx_if.valid <= 1'b1;
				rx_if.rx_byte <= tx_bytes.pop_front();
				if ($urandom_range(0, 49) == 0)
					src_calm <= !src_calm;
				src_wait <= draw_idle(src_calm);
			end else begin
				rx_if.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	// Predict on each byte transfer, check each record transfer, then stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_if.ready <= 1'b1;
			sink_wait <= 0;
			sink_calm <= 1'b0;
		end else begin
			if (rx_if.valid && rx_if.ready) begin
				parse_byte(rx_if.rx_byte);
				bytes_taken++;
			end
			if (fix_if.valid && fix_if.ready) begin
				check_fix();
				if ($urandom_range(0, 49) == 0)
					sink_calm <= !sink_calm;
				sink_draw = draw_idle(sink_calm);
				if (sink_draw != 0) begin
					fix_if.ready <= 1'b0;
					sink_wait <= sink_draw;
				end
			end else if (sink_wait != 0) begin
				sink_wait <= sink_wait - 1;
				if (sink_wait == 1)
					fix_if.ready <= 1'b1;
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		rx_if.valid = 1'b0;
		rx_if.rx_byte = 8'h00;
		fix_if.ready = 1'b0;
		arst_n = 1'b0;
		reset_model();
		build_stimulus();
		byte_total = tx_bytes.size();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// wait for every byte and every fix record, then drain
		while (bytes_taken != byte_total || fix_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
